// ----- src/smt_pkg.sv -----
// shared types and codes for the set membership table
package smt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_PRESENT = 2'd1;
    localparam logic [1:0] STATUS_ABSENT  = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [KEY_W-1:0] key;
    } request_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

    // lookup token that walks the cell chain
    typedef struct packed {
        logic active;
        logic found;
        logic free_seen;
    } token_t;

endpackage

// ----- src/smt_cell.sv -----
// one table slot: key, valid bit and the token stage to the next slot
module smt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  smt_pkg::request_t req,
    input  logic            commit,
    input  smt_pkg::token_t tok_in,
    output smt_pkg::token_t tok_out
);
    import smt_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    cand_reg;
    logic                    cand_next;
    token_t                  tok_reg;
    token_t                  tok_next;
    logic                    match;

    assign match = valid_reg && (key_reg == req.key);

    always_comb
    begin
        tok_next.active    = tok_in.active;
        tok_next.found     = tok_in.found | match;
        tok_next.free_seen = tok_in.free_seen | ~valid_reg;

        valid_next = valid_reg;
        if (tok_in.active && (req.op == OP_DELETE) && match)
        begin
            valid_next = 1'b0;
        end
        else if (commit && cand_reg)
        begin
            valid_next = 1'b1;
        end

        cand_next = cand_reg;
        if (tok_in.active)
        begin
            cand_next = ~tok_in.free_seen & ~valid_reg;
        end
        else if (commit)
        begin
            cand_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && cand_reg)
        begin
            key_reg <= req.key;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- src/set_membership_table.sv -----
// Set membership table: a set of up to CAPACITY signed 32-bit keys held in a chain of slot cells.
// One request (insert, delete or search) is handled at a time. A lookup token walks the
// chain one cell per clock. From acceptance to result, the token passes through the cells,
// is captured at the end of the chain, and the close-out then loads the result and commits
// an insert into the lowest free slot. The next request is taken the cycle after the result
// is loaded into the output register, even if it is still stalled, so a new request is not
// accepted before the previous one has been closed out.
// A result still stalled in the output register holds the close-out until it is taken.
// The valid bits clear at reset; no clearing pass is needed.
module set_membership_table #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  smt_pkg::request_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output smt_pkg::result_t  rsp
);
    import smt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    request_t         req_reg;
    logic             start_reg;
    token_t           fin_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    result_t          rsp_reg;
    result_t          rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             accept;
    logic             finish;
    logic             commit;
    logic [1:0]       status_c;
    logic [CNT_W+COUNT_W-1:0] count_ext;
    token_t           tok [CAPACITY+1];

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign finish    = (state_reg == S_FIN) && (!rsp_valid_reg || !rsp_stall);

    assign tok[0] = '{active: start_reg, found: 1'b0, free_seen: 1'b0};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        smt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req     (req_reg),
            .commit  (commit),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    always_comb
    begin
        status_c   = STATUS_DONE;
        commit     = 1'b0;
        count_next = count_reg;
        unique case (req_reg.op)
            OP_INSERT:
            begin
                if (fin_reg.found)
                begin
                    status_c = STATUS_PRESENT;
                end
                else if (!fin_reg.free_seen)
                begin
                    status_c = STATUS_FULL;
                end
                else
                begin
                    status_c   = STATUS_DONE;
                    commit     = finish;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (fin_reg.found)
                begin
                    status_c = STATUS_DONE;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    status_c = STATUS_ABSENT;
                end
            end
            default:
            begin
                status_c = fin_reg.found ? STATUS_DONE : STATUS_ABSENT;
            end
        endcase
    end

    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next.hit         = fin_reg.found;
        rsp_next.status      = status_c;
        rsp_next.entry_count = count_ext[COUNT_W-1:0];

        rsp_valid_next = rsp_valid_reg;
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept)           state_next = S_RUN;
            S_RUN:   if (tok[CAPACITY].active) state_next = S_FIN;
            S_FIN:   if (finish)           state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= accept;
            rsp_valid_reg <= rsp_valid_next;
            if (finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if ((state_reg == S_RUN) && tok[CAPACITY].active)
        begin
            fin_reg <= tok[CAPACITY];
        end
        if (finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
